// File: sv/aligned_pair_distance_core_assert.svh
// Assertion macros for the aligned pair distance core.
// Used by the top level; expects clk and arst_n in scope.
`ifndef ALIGNED_PAIR_DISTANCE_CORE_ASSERT_SVH
`define ALIGNED_PAIR_DISTANCE_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define APD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define APD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/apd_pkg.sv
// Shared types, constants and character tables of the aligned pair distance core.
// No dependencies; imported by the controller, the datapath and the top level.
package apd_pkg;

	localparam int QUO_BITS   = 32;
	localparam int ROOT_BITS  = 16;
	localparam int DIST_BITS  = 17;
	localparam int TOT_BITS   = 16;
	localparam int DIV_STEPS  = QUO_BITS;
	localparam int ROOT_STEPS = ROOT_BITS;
	localparam int STEP_BITS  = $clog2(DIV_STEPS);

	localparam logic [DIST_BITS-1:0] DIST_ONE = DIST_BITS'(1) << ROOT_BITS;

	localparam logic [1:0] REG_SEQ_KIND   = 2'd0;
	localparam logic [1:0] REG_PROT_MAT   = 2'd1;
	localparam logic [1:0] REG_GAP_COUNT  = 2'd2;

	localparam logic       KIND_DNA     = 1'b1;
	localparam logic [1:0] MATRIX_GROUP = 2'd1;
	localparam logic [1:0] MATRIX_IDENT = 2'd2;

	localparam logic [7:0] CH_GAP  = 8'h2D;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_N    = 8'h4E;
	localparam logic [7:0] CH_X    = 8'h58;

	typedef struct packed {
		logic       seq_kind;
		logic [1:0] prot_mat;
		logic       gap_count;
	} cfg_t;

	typedef struct packed {
		logic score;
		logic capture;
		logic div_step;
		logic root_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic none;
		logic full;
	} stat_t;

	// A C G T X N -
	function automatic logic dna_member(input logic [7:0] ch);
		logic hit;
		case (ch)
			8'h41, 8'h43, 8'h47, 8'h54, 8'h58, 8'h4E, 8'h2D: hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	// D E K R H N Q S T I L V F W Y C M A G P X * -
	function automatic logic prot_member(input logic [7:0] ch);
		logic hit;
		case (ch)
			8'h44, 8'h45, 8'h4B, 8'h52, 8'h48, 8'h4E, 8'h51, 8'h53, 8'h54,
			8'h49, 8'h4C, 8'h56, 8'h46, 8'h57, 8'h59, 8'h43, 8'h4D,
			8'h41, 8'h47, 8'h50, 8'h58, 8'h2A, 8'h2D: hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	// residue groups: polar/charged, hydrophobic, small, proline
	function automatic logic [1:0] group_of(input logic [7:0] ch);
		logic [1:0] grp;
		case (ch)
			8'h49, 8'h4C, 8'h56, 8'h46, 8'h57, 8'h59, 8'h43, 8'h4D: grp = 2'd1;
			8'h41, 8'h47: grp = 2'd2;
			8'h50: grp = 2'd3;
			default: grp = 2'd0;
		endcase
		return grp;
	endfunction

endpackage

// File: sv/aligned_pair_distance_core.sv
// Top level of the aligned pair distance core: configuration registers,
// controller and datapath. Depends on apd_pkg, apd_ctrl, apd_dpath and the assert header.
//
//  channel   direction  handshake          payload
//  cfg       in         cfg_en             cfg_index, cfg_data
//  s_*       in         s_tvalid/s_tready  s_tdata, s_tlast
//  m_*       out        m_tvalid/m_tready  m_tdata, m_tuser
//
// Columns that do not end their pair are accepted back to back.
// After a final column the controller runs a check, 32 divider steps, 16 root steps
// and a load of the result; with no compared site or a ratio of one it goes from check to load.
// The word is held in an output register, so new columns flow while it waits.
// s_tready is low during the check, while the divider and root run, or while a result waits to be loaded.
// Reset clears counts and control; configuration returns to DNA, identity, no gaps.
`include "aligned_pair_distance_core_assert.svh"

module aligned_pair_distance_core #(
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_en,
	input  logic [1:0]  cfg_index,
	input  logic [1:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // residue_first[7:0], residue_second[15:8]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // distance_value[16:0], difference_total[32:17],
	                               // compared_total[48:33], zero[55:49]
	output logic [0:0]  m_tuser    // nothing_compared[0]
);
	import apd_pkg::*;

	cfg_t  cfg_q;
	cmd_t  cmd;
	stat_t stat;

	logic [DIST_BITS-1:0] distance_value;
	logic [TOT_BITS-1:0]  difference_total;
	logic [TOT_BITS-1:0]  compared_total;
	logic                 nothing_compared;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.seq_kind  <= KIND_DNA;
			cfg_q.prot_mat  <= MATRIX_IDENT;
			cfg_q.gap_count <= 1'b0;
		end else if (cfg_en) begin
			unique case (cfg_index)
				REG_SEQ_KIND:  cfg_q.seq_kind  <= cfg_data[0];
				REG_PROT_MAT:  cfg_q.prot_mat  <= cfg_data;
				REG_GAP_COUNT: cfg_q.gap_count <= cfg_data[0];
				default: ;
			endcase
		end
	end

	apd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	apd_dpath #(
		.COUNT_BITS (COUNT_BITS)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.cmd              (cmd),
		.stat             (stat),
		.residue_first    (s_tdata[7:0]),
		.residue_second   (s_tdata[15:8]),
		.distance_value   (distance_value),
		.difference_total (difference_total),
		.compared_total   (compared_total),
		.nothing_compared (nothing_compared)
	);

	assign m_tdata    = {7'b0, compared_total, difference_total, distance_value};
	assign m_tuser[0] = nothing_compared;

	`APD_ASSERT_NOW(a_none_is_zero, m_tvalid && m_tuser[0], (m_tdata[32:0] == 33'd0), "empty pair with nonzero distance or difference")
	`APD_ASSERT_NOW(a_one_is_exact, m_tvalid && m_tdata[16], (m_tdata[15:0] == 16'd0), "distance above one")
	`APD_ASSERT_NEXT(a_busy_after_last, s_tvalid && s_tready && s_tlast, !s_tready, "column taken while pair result is pending")

endmodule

// File: sv/apd_ctrl.sv
// Controller of the aligned pair distance core: sequences scoring, division and root.
// Depends on apd_pkg for the command and status structs and step counts.
module apd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	input  logic          s_tlast,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	input  apd_pkg::stat_t stat,
	output apd_pkg::cmd_t  cmd
);
	import apd_pkg::*;

	typedef enum logic [2:0] {
		ST_ACCUM,
		ST_CHECK,
		ST_DIV,
		ST_ROOT,
		ST_HOLD
	} state_t;

	state_t               state_q;
	logic [STEP_BITS-1:0] step_q;
	logic                 m_tvalid_q;
	logic                 accept;
	logic                 out_free;

	assign s_tready = (state_q == ST_ACCUM);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd           = '0;
		cmd.score     = accept;
		cmd.capture   = accept && s_tlast;
		cmd.div_step  = (state_q == ST_DIV);
		cmd.root_step = (state_q == ST_ROOT);
		cmd.out_load  = (state_q == ST_HOLD) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_ACCUM;
			step_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				ST_ACCUM: begin
					if (accept && s_tlast)
						state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					step_q <= '0;
					if (stat.none || stat.full)
						state_q <= ST_HOLD;
					else
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (step_q == STEP_BITS'(DIV_STEPS - 1)) begin
						step_q  <= '0;
						state_q <= ST_ROOT;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_ROOT: begin
					if (step_q == STEP_BITS'(ROOT_STEPS - 1))
						state_q <= ST_HOLD;
					else
						step_q <= step_q + 1'b1;
				end
				ST_HOLD: begin
					if (out_free)
						state_q <= ST_ACCUM;
				end
				default: state_q <= ST_ACCUM;
			endcase
		end
	end

endmodule

// File: sv/apd_dpath.sv
// Datapath of the aligned pair distance core: column scoring, saturating counts,
// restoring divider, bit-serial square root and the result register. Uses apd_pkg.
module apd_dpath #(
	parameter int COUNT_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  apd_pkg::cfg_t                  cfg,
	input  apd_pkg::cmd_t                  cmd,
	output apd_pkg::stat_t                 stat,
	input  logic [7:0]                     residue_first,
	input  logic [7:0]                     residue_second,
	output logic [apd_pkg::DIST_BITS-1:0]  distance_value,
	output logic [apd_pkg::TOT_BITS-1:0]   difference_total,
	output logic [apd_pkg::TOT_BITS-1:0]   compared_total,
	output logic                           nothing_compared
);
	import apd_pkg::*;

	localparam int REM_BITS      = COUNT_BITS + 1;
	localparam int ROOT_REM_BITS = ROOT_BITS + 2;
	localparam int ROOT_WORK     = ROOT_REM_BITS + 2;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	logic [7:0] a;
	logic [7:0] b;
	logic dna_ok, dna_skip_a, dna_skip_b, dna_site, dna_gap;
	logic prot_ok, prot_skip_a, prot_skip_b, prot_site, prot_diff;
	logic site_inc, diff_inc;

	logic [COUNT_BITS-1:0] diff_cnt_q, site_cnt_q;
	logic [COUNT_BITS-1:0] diff_next, site_next;

	logic [REM_BITS-1:0]      rem_q;
	logic [COUNT_BITS-1:0]    dvsr_q;
	logic [QUO_BITS-1:0]      quo_q;
	logic [REM_BITS-1:0]      div_trial;
	logic                     div_ge;
	logic [ROOT_REM_BITS-1:0] sq_rem_q;
	logic [ROOT_BITS-1:0]     root_q;
	logic [ROOT_WORK-1:0]     root_work, root_trial;
	logic                     root_ge;
	logic [TOT_BITS-1:0]      diff_tot_q, site_tot_q;
	logic                     none_q, full_q;

	logic [DIST_BITS-1:0] dist_out_q;
	logic [TOT_BITS-1:0]  diff_out_q, site_out_q;
	logic                 none_out_q;

	assign a = residue_first;
	assign b = residue_second;

	assign dna_ok     = dna_member(a) && dna_member(b);
	assign dna_skip_a = (a == CH_GAP) || (a == CH_N) || (a == CH_X);
	assign dna_skip_b = (b == CH_GAP) || (b == CH_N) || (b == CH_X);
	assign dna_site   = dna_ok && !dna_skip_a && !dna_skip_b;
	assign dna_gap    = dna_ok && cfg.gap_count &&
		(((a == CH_GAP) && !dna_skip_b) || ((b == CH_GAP) && !dna_skip_a));

	assign prot_ok     = prot_member(a) && prot_member(b) &&
		((cfg.prot_mat == MATRIX_GROUP) || (cfg.prot_mat == MATRIX_IDENT));
	assign prot_skip_a = (a == CH_GAP) || (a == CH_STAR) || (a == CH_X);
	assign prot_skip_b = (b == CH_GAP) || (b == CH_STAR) || (b == CH_X);
	assign prot_site   = prot_ok && !prot_skip_a && !prot_skip_b;
	assign prot_diff   = prot_site && ((cfg.prot_mat == MATRIX_IDENT) ? (a != b) :
		(group_of(a) != group_of(b)));

	assign site_inc = (cfg.seq_kind == KIND_DNA) ? (dna_site || dna_gap) : prot_site;
	assign diff_inc = (cfg.seq_kind == KIND_DNA) ? ((dna_site && (a != b)) || dna_gap) :
		prot_diff;

	assign site_next = (site_inc && (site_cnt_q != COUNT_MAX)) ? site_cnt_q + 1'b1 : site_cnt_q;
	assign diff_next = (diff_inc && (diff_cnt_q != COUNT_MAX)) ? diff_cnt_q + 1'b1 : diff_cnt_q;

	assign div_trial = {rem_q[COUNT_BITS-1:0], 1'b0};
	assign div_ge    = (div_trial >= {1'b0, dvsr_q});

	assign root_work  = {sq_rem_q, quo_q[QUO_BITS-1 -: 2]};
	assign root_trial = {2'b00, root_q, 2'b01};
	assign root_ge    = (root_work >= root_trial);

	assign stat.none = none_q;
	assign stat.full = full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diff_cnt_q <= '0;
			site_cnt_q <= '0;
		end else if (cmd.capture) begin
			diff_cnt_q <= '0;
			site_cnt_q <= '0;
		end else if (cmd.score) begin
			diff_cnt_q <= diff_next;
			site_cnt_q <= site_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rem_q      <= {1'b0, diff_next};
			dvsr_q     <= site_next;
			quo_q      <= '0;
			sq_rem_q   <= '0;
			root_q     <= '0;
			diff_tot_q <= TOT_BITS'(diff_next);
			site_tot_q <= TOT_BITS'(site_next);
			none_q     <= (site_next == '0);
			full_q     <= (diff_next >= site_next);
		end
		if (cmd.div_step) begin
			rem_q <= div_ge ? (div_trial - {1'b0, dvsr_q}) : div_trial;
			quo_q <= {quo_q[QUO_BITS-2:0], div_ge};
		end
		if (cmd.root_step) begin
			sq_rem_q <= ROOT_REM_BITS'(root_ge ? (root_work - root_trial) : root_work);
			root_q   <= {root_q[ROOT_BITS-2:0], root_ge};
			quo_q    <= quo_q << 2;
		end
		if (cmd.out_load) begin
			if (none_q)
				dist_out_q <= '0;
			else if (full_q)
				dist_out_q <= DIST_ONE;
			else
				dist_out_q <= {1'b0, root_q};
			diff_out_q <= diff_tot_q;
			site_out_q <= site_tot_q;
			none_out_q <= none_q;
		end
	end

	assign distance_value   = dist_out_q;
	assign difference_total = diff_out_q;
	assign compared_total   = site_out_q;
	assign nothing_compared = none_out_q;

endmodule
